[rtl/polygon_mesh_area_accumulator_top_macros.svh]
// Assertion macros for the top level, which checks its own behavior.
`ifndef POLYGON_MESH_AREA_ACCUMULATOR_TOP_MACROS_SVH
`define POLYGON_MESH_AREA_ACCUMULATOR_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PMA_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PMA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[rtl/pma_pkg.sv]
// Package with the widths, types and constants of the mesh area accumulator.
package pma_pkg;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned AreaBits  = 48;
  localparam int unsigned OutBits   = 48;
  localparam int unsigned TriBits   = 32;
  // Edge differences need one more bit; cross components two times that plus one.
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned CrossBits = 2 * DiffBits + 1;
  localparam int unsigned MagBits   = CrossBits - 1;
  localparam int unsigned SumBits   = 2 * MagBits + 2;
  localparam int unsigned RootBits  = SumBits / 2;
  localparam int unsigned RootIdxBits = $clog2(RootBits);

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef struct packed {
    logic [OutBits-1:0] area_total;
    logic [TriBits-1:0] triangle_total;
    logic               area_saturated;
  } result_t;

  typedef struct packed {
    vertex_t vert;
    logic    face_start;
    logic    mesh_end;
  } request_t;
endpackage

[rtl/pma_stream_if.sv]
// Valid/ready channel carrying one payload type.
interface pma_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/polygon_mesh_area_accumulator_top.sv]
// Top level of the polygon mesh area accumulator.
//
//   port    dir  payload                                   role
//   vert_i  in   vert {x,y,z}, face_start, mesh_end         one vertex per request
//   res_o   out  area_total, triangle_total, area_saturated one result per mesh end
//
// A vertex that only opens or extends a polygon is accepted and then finished. A vertex
// that closes a fan triangle passes through the accept, the start of the unit, the edge
// differences, seven steps on the shared multiplier for the cross product, three squares,
// 35 steps of the bit-serial root, the addition of the term and the finish.
// Reset clears all control and totals at once. The block takes no new vertex while a
// vertex is in work. A mesh result that waits in the output register stalls the block
// only when the next mesh end is ready to be emitted.
module polygon_mesh_area_accumulator_top (
  input  logic clk_i,
  input  logic rst_ni,
  pma_stream_if.sink   vert_i,
  pma_stream_if.source res_o
);
  import pma_pkg::*;
  `include "polygon_mesh_area_accumulator_top_macros.svh"

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StKick = 4'b0010,
    StWait = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  localparam logic [AreaBits-1:0] AreaMax = '1;
  localparam logic [TriBits-1:0]  TriMax  = '1;

  state_e state_q, state_d;
  vertex_t anchor_q, prev_q, cur_q;
  logic mesh_end_q;
  logic [1:0] fvc_q;
  logic [AreaBits-1:0] area_q;
  logic [TriBits-1:0] tri_q;
  logic sat_q;
  logic out_valid_q;
  result_t out_q;
  logic done_q;

  logic start;
  logic done;
  logic [RootBits-2:0] term;
  logic [AreaBits:0] area_sum;
  request_t req;
  logic finish;
  logic emit;

  assign req = vert_i.payload;
  assign vert_i.ready = (state_q == StIdle);
  assign res_o.valid = out_valid_q;
  assign res_o.payload = out_q;
  assign start = (state_q == StKick);

  pma_tri_unit u_tri (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .anchor_i (anchor_q),
    .prev_i   (prev_q),
    .cur_i    (cur_q),
    .done_o   (done),
    .term_o   (term)
  );

  // The unit flags its last root step; the term is taken in the cycle after, via the registered flag.
  assign finish = (state_q == StWait) && done_q;
  // A mesh result leaves when the output register is free or being drained.
  assign emit = (state_q == StFin) && mesh_end_q && (!out_valid_q || res_o.ready);

  assign area_sum = {1'b0, area_q} + (AreaBits+1)'(term);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (vert_i.valid && vert_i.ready) begin
        if (!req.face_start && fvc_q == 2'd2) state_d = StKick;
        else state_d = StFin;
      end
      StKick: state_d = StWait;
      StWait: if (finish) state_d = StFin;
      StFin:  if (!mesh_end_q || emit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fvc_q <= '0;
      area_q <= '0;
      tri_q <= '0;
      sat_q <= 1'b0;
      out_valid_q <= 1'b0;
      done_q <= 1'b0;
      anchor_q <= '0;
      prev_q <= '0;
      mesh_end_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done;
      if (emit) out_valid_q <= 1'b1;
      else if (res_o.valid && res_o.ready) out_valid_q <= 1'b0;
      if (vert_i.valid && vert_i.ready) begin
        mesh_end_q <= req.mesh_end;
        if (req.face_start || fvc_q == 2'd0) begin
          anchor_q <= req.vert;
          fvc_q <= 2'd1;
        end else if (fvc_q == 2'd1) begin
          prev_q <= req.vert;
          fvc_q <= 2'd2;
        end
      end
      if (finish) begin
        if (sat_q || area_sum[AreaBits]) begin
          area_q <= AreaMax;
          sat_q <= 1'b1;
        end else begin
          area_q <= area_sum[AreaBits-1:0];
        end
        if (tri_q != TriMax) tri_q <= tri_q + 1'b1;
        prev_q <= cur_q;
      end
      if (emit) begin
        area_q <= '0;
        tri_q <= '0;
        sat_q <= 1'b0;
        fvc_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vert_i.valid && vert_i.ready) cur_q <= req.vert;
    if (emit) begin
      out_q.area_total     <= OutBits'(area_q);
      out_q.triangle_total <= tri_q;
      out_q.area_saturated <= sat_q;
    end
  end

  `PMA_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != StIdle, !vert_i.ready)
  `PMA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, res_o.valid && !res_o.ready, res_o.valid)
  `PMA_ASSERT_IMP(a_sat_max, clk_i, rst_ni, sat_q, area_q == AreaMax)
endmodule

[rtl/pma_tri_unit.sv]
// Sequenced triangle term unit: cross product, sum of squares and bit-serial root.
module pma_tri_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  pma_pkg::vertex_t           anchor_i,
  input  pma_pkg::vertex_t           prev_i,
  input  pma_pkg::vertex_t           cur_i,
  output logic                       done_o,
  output logic [pma_pkg::RootBits-2:0] term_o
);
  import pma_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StDiff  = 5'b00010,
    StMul   = 5'b00100,
    StSq    = 5'b01000,
    StRoot  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [RootIdxBits-1:0] bit_q, bit_d;
  logic signed [DiffBits-1:0] e1_q [3], e2_q [3];
  logic signed [CrossBits-1:0] cr_q [3];
  logic [SumBits-1:0] sum_q, rem_q;
  logic [RootBits-1:0] root_q;
  logic [2*DiffBits-1:0] prod_q;

  // One shared signed multiplier, operands chosen by the step counter.
  logic signed [DiffBits-1:0] ma, mb;
  logic signed [2*DiffBits-1:0] mp;
  logic [MagBits-1:0] mag;
  logic [2*MagBits-1:0] sq;
  logic [1:0] comp;
  logic [SumBits-1:0] trial;
  logic [SumBits-1:0] rem_sh;

  always_comb begin
    ma = e1_q[0];
    mb = e2_q[0];
    case (step_q)
      3'd0: begin ma = e1_q[1]; mb = e2_q[2]; end
      3'd1: begin ma = e1_q[2]; mb = e2_q[1]; end
      3'd2: begin ma = e1_q[2]; mb = e2_q[0]; end
      3'd3: begin ma = e1_q[0]; mb = e2_q[2]; end
      3'd4: begin ma = e1_q[0]; mb = e2_q[1]; end
      3'd5: begin ma = e1_q[1]; mb = e2_q[0]; end
      default: begin ma = e1_q[0]; mb = e2_q[0]; end
    endcase
    mp = ma * mb;
  end

  always_comb begin
    comp = step_q[1:0];
    mag = cr_q[comp][CrossBits-1] ? MagBits'(-cr_q[comp]) : cr_q[comp][MagBits-1:0];
    sq = mag * mag;
    // Restoring square root, two radicand bits per step.
    rem_sh = {rem_q[SumBits-3:0], sum_q[SumBits-1 -: 2]};
    trial = SumBits'({root_q, 2'b01});
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bit_d   = bit_q;
    case (state_q)
      StIdle: if (start_i) state_d = StDiff;
      StDiff: begin state_d = StMul; step_d = '0; end
      StMul: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) begin state_d = StSq; step_d = '0; end
      end
      StSq: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd2) begin
          state_d = StRoot;
          bit_d = RootIdxBits'(RootBits - 1);
        end
      end
      StRoot: begin
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StDiff: begin
        e1_q[0] <= DiffBits'(prev_i.x) - DiffBits'(anchor_i.x);
        e1_q[1] <= DiffBits'(prev_i.y) - DiffBits'(anchor_i.y);
        e1_q[2] <= DiffBits'(prev_i.z) - DiffBits'(anchor_i.z);
        e2_q[0] <= DiffBits'(cur_i.x) - DiffBits'(anchor_i.x);
        e2_q[1] <= DiffBits'(cur_i.y) - DiffBits'(anchor_i.y);
        e2_q[2] <= DiffBits'(cur_i.z) - DiffBits'(anchor_i.z);
      end
      StMul: begin
        // Steps 0, 2 and 4 latch the first product, odd steps subtract the second; step 6 clears the sum.
        if (!step_q[0] && step_q != 3'd6) prod_q <= mp;
        if (step_q[0]) cr_q[step_q[2:1]] <=
          CrossBits'($signed(prod_q)) - CrossBits'(mp);
        if (step_q == 3'd6) sum_q <= '0;
      end
      StSq: begin
        sum_q <= sum_q + SumBits'(sq);
        rem_q <= '0;
        root_q <= '0;
      end
      StRoot: begin
        sum_q <= {sum_q[SumBits-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RootBits-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RootBits-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // High during the last root step; the term is valid from the next cycle on.
  assign done_o = (state_q == StRoot) && (bit_q == '0);
  assign term_o = root_q[RootBits-1:1];
endmodule

[tb/polygon_mesh_area_accumulator_top_tb.sv]
// Self-checking testbench for the polygon mesh area accumulator top level.
module polygon_mesh_area_accumulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pma_pkg::*;

  localparam int unsigned LimitCycles = 400000;
  localparam logic [AreaBits-1:0] AreaMax = '1;
  localparam logic [TriBits-1:0] TriMax = '1;

  // Scoreboard: a copy of the mesh state and a queue of expected mesh totals.
  class mesh_area_board;
    logic signed [CoordBits-1:0] anchor[3];
    logic signed [CoordBits-1:0] prev[3];
    int unsigned                 vert_count;
    logic [AreaBits-1:0]         area_acc;
    logic [TriBits-1:0]          tri_cnt;
    logic                        sat;
    result_t                     totals_q[$];
    int unsigned                 mismatches;

    function new();
      for (int i = 0; i < 3; i++) begin
        anchor[i] = '0;
        prev[i] = '0;
      end
      vert_count = 0;
      area_acc = '0;
      tri_cnt = '0;
      sat = 1'b0;
      mismatches = 0;
    endfunction

    // Half the norm of the cross product of the two fan edges, floored.
    function logic [63:0] half_cross_norm(logic signed [CoordBits-1:0] cur[3]);
      logic signed [63:0] e1[3];
      logic signed [63:0] e2[3];
      logic signed [63:0] c[3];
      logic [127:0] s;
      logic [127:0] mg;
      logic [63:0] root;
      logic [63:0] cand;
      for (int i = 0; i < 3; i++) begin
        e1[i] = 64'(prev[i]) - 64'(anchor[i]);
        e2[i] = 64'(cur[i]) - 64'(anchor[i]);
      end
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      s = '0;
      for (int i = 0; i < 3; i++) begin
        // Square the magnitude at full width; the square can exceed 63 bits.
        mg = 128'((c[i] < 0) ? -c[i] : c[i]);
        s += mg * mg;
      end
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= s) root = cand;
      end
      return root >> 1;
    endfunction

    function void note_vertex(request_t req);
      logic signed [CoordBits-1:0] v[3];
      logic [63:0] term;
      result_t r;
      v[0] = req.vert.x;
      v[1] = req.vert.y;
      v[2] = req.vert.z;
      if (req.face_start || vert_count == 0) begin
        anchor = v;
        vert_count = 1;
      end else if (vert_count == 1) begin
        prev = v;
        vert_count = 2;
      end else begin
        term = half_cross_norm(v);
        if (sat || term > 64'(AreaMax - area_acc)) begin
          area_acc = AreaMax;
          sat = 1'b1;
        end else begin
          area_acc += AreaBits'(term);
        end
        if (tri_cnt != TriMax) tri_cnt++;
        prev = v;
      end
      if (req.mesh_end) begin
        r.area_total = OutBits'(area_acc);
        r.triangle_total = tri_cnt;
        r.area_saturated = sat;
        totals_q.push_back(r);
        area_acc = '0;
        tri_cnt = '0;
        sat = 1'b0;
        vert_count = 0;
      end
    endfunction

    function void check_total(result_t got);
      result_t want;
      if (totals_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected mesh total %p", got);
        return;
      end
      want = totals_q.pop_front();
      if (got.area_total !== want.area_total || got.triangle_total !== want.triangle_total
          || got.area_saturated !== want.area_saturated) begin
        mismatches++;
        if (mismatches <= 10) $display("mesh total mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;

  pma_stream_if #(.payload_t(request_t)) vert_if ();
  pma_stream_if #(.payload_t(result_t))  res_if ();

  polygon_mesh_area_accumulator_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vert_i(vert_if.sink),
    .res_o (res_if.source)
  );

  mesh_area_board board = new();

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Gap length: mostly zero or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Sender: holds one request until the handshake completes, then maybe idles.
  task automatic send_vertex(request_t req);
    int unsigned gap;
    vert_if.valid <= 1'b1;
    vert_if.payload <= req;
    do @(posedge clk_i); while (!vert_if.ready);
    board.note_vertex(req);
    sent_count++;
    gap = gap_len();
    if (gap != 0) begin
      vert_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic request_t make_vertex(coord_t x, coord_t y, coord_t z, logic fs, logic me);
    request_t r;
    r.vert.x = x;
    r.vert.y = y;
    r.vert.z = z;
    r.face_start = fs;
    r.mesh_end = me;
    return r;
  endfunction

  // Coordinates are often small so that most meshes do not saturate, sometimes the full range.
  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'($signed(12'($urandom)));
    endcase
  endfunction

  // A well-formed mesh: a few faces of three to six vertices; occasionally broken.
  task automatic send_random_mesh();
    int unsigned faces;
    int unsigned verts;
    faces = $urandom_range(4, 1);
    for (int f = 0; f < faces; f++) begin
      verts = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(6, 3);
      for (int v = 0; v < verts; v++) begin
        send_vertex(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                (v == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                                (f == faces - 1 && v == verts - 1)));
      end
    end
  endtask

  // Receiver: ready toggles with random gaps, results are checked when accepted.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) board.check_total(res_if.payload);
      if (res_if.ready && $urandom_range(3) == 0) begin
        res_if.ready <= 1'b0;
      end else if (!res_if.ready && $urandom_range(9) < 4) begin
        res_if.ready <= 1'b1;
      end else if (!res_if.ready && $urandom_range(49) == 0) begin
        repeat (gap_len()) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    coord_t m;
    vert_if.valid = 1'b0;
    vert_if.payload = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A vertex without face start after reset opens a polygon.
    send_vertex(make_vertex(16'sh0100, 16'sd0, 16'sd0, 1'b0, 1'b0));
    send_vertex(make_vertex(16'sd0, 16'sh0100, 16'sd0, 1'b0, 1'b0));
    send_vertex(make_vertex(16'sd0, 16'sd0, 16'sh0100, 1'b0, 1'b0));
    // A quad closed by the mesh end vertex.
    send_vertex(make_vertex(16'sh0100, 16'sh0100, 16'sh0100, 1'b0, 1'b1));
    // Both flags on one vertex: empty mesh total.
    send_vertex(make_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 1'b1));
    // One and two vertex polygons, then a degenerate (collinear) triangle.
    send_vertex(make_vertex(16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b0));
    send_vertex(make_vertex(16'sd1, 16'sd2, 16'sd3, 1'b1, 1'b0));
    send_vertex(make_vertex(16'sd4, 16'sd5, 16'sd6, 1'b0, 1'b0));
    send_vertex(make_vertex(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0));
    send_vertex(make_vertex(16'sh0200, 16'sh0200, 16'sh0200, 1'b0, 1'b0));
    send_vertex(make_vertex(16'sh0400, 16'sh0400, 16'sh0400, 1'b0, 1'b1));
    // Extreme triangles drive the total toward saturation.
    m = 16'sh8000;
    send_vertex(make_vertex(m, m, m, 1'b1, 1'b0));
    send_vertex(make_vertex(16'sh7fff, m, 16'sh7fff, 1'b0, 1'b0));
    for (int i = 0; i < 10; i++) begin
      send_vertex(make_vertex((i % 2) ? m : 16'sh7fff, 16'sh7fff, (i % 2) ? 16'sh7fff : m,
                              1'b0, i == 9));
    end

    // Let everything drain before the random part.
    vert_if.valid <= 1'b0;
    while (board.totals_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    // Long run of huge triangles inside one mesh builds a large total.
    send_vertex(make_vertex(m, m, m, 1'b1, 1'b0));
    send_vertex(make_vertex(16'sh7fff, m, m, 1'b0, 1'b0));
    for (int i = 0; i < 40; i++) begin
      send_vertex(make_vertex((i % 2) ? 16'sh7fff : m, 16'sh7fff, 16'sh7fff, 1'b0, i == 39));
    end

    while (sent_count < 1070) begin
      if ($urandom_range(19) == 0) begin
        // Noise vertex with random flags.
        send_vertex(make_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                                1'($urandom), 1'($urandom)));
      end else begin
        send_random_mesh();
      end
    end
    // Close any open mesh.
    send_vertex(make_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1));
    vert_if.valid <= 1'b0;

    while (board.totals_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
